@@ rtl/bsmm_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bsmm_pkg
// Shared constants, types and codes for the block-sparse matrix multiplier.
// ---------------------------------------------------------------------------
package bsmm_pkg;

  localparam int DEPTH_K    = 256;
  localparam int MAX_COLS   = 64;
  localparam int LANES      = 4;
  localparam int ROW_W      = $clog2(DEPTH_K);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int BANK_AW    = ROW_W - 2 + COL_W;
  localparam int BANK_DEPTH = (DEPTH_K / LANES) * MAX_COLS;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 32;
  localparam int VAL_W      = 16;
  localparam int CVAL_W     = 48;
  localparam int NCOL_W     = 7;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BLOCK = 2'd1;
  localparam logic [1:0] REQ_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_EMIT,
    ST_EMIT_END
  } state_t;

  typedef struct packed {
    logic             b_wr;
    logic             blk_load;
    logic             empty_load;
    logic             row_first;
    logic             acc_issue;
    logic             emit_issue;
    logic [COL_W-1:0] col;
    logic             col_last;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic rd_pend;
    logic out_stall;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/bsmm_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bsmm_ctrl
// Sequencer: accepts transactions, steps columns for accumulate and emit.
// ---------------------------------------------------------------------------
module bsmm_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   req_type,
  input  wire logic                         last_block,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bsmm_pkg::NCOL_W-1:0]  cfg_data,
  input  wire bsmm_pkg::status_t            st,
  output bsmm_pkg::cmd_t                    cmd
);
  import bsmm_pkg::*;

  state_t            state, state_next;
  logic [NCOL_W-1:0] n_cols;
  logic [NCOL_W-1:0] n_eff;
  logic [COL_W-1:0]  last_col;
  logic [COL_W-1:0]  cnt;
  logic              row_open;
  logic              blk_last;
  logic              accept;

  assign cfg_ready = 1'b1;

  // low two bits dropped, zero acts as four, clamp at MAX_COLS
  always_comb begin
    n_eff = {n_cols[NCOL_W-1:2], 2'b00};
    if (n_eff == '0) n_eff = NCOL_W'(LANES);
    if (n_eff > NCOL_W'(MAX_COLS)) n_eff = NCOL_W'(MAX_COLS);
    last_col = COL_W'(n_eff - NCOL_W'(1));
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_BLOCK) state_next = ST_ACC;
        else if (accept && req_type == REQ_EMPTY) state_next = ST_EMIT;
      end
      ST_ACC: begin
        if (cnt == last_col) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) state_next = blk_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (cmd.emit_issue && cmd.col_last) state_next = ST_EMIT_END;
      end
      ST_EMIT_END: begin
        if (!st.rd_pend) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd.b_wr       = accept && (req_type == REQ_LOAD);
    cmd.blk_load   = accept && (req_type == REQ_BLOCK);
    cmd.empty_load = accept && (req_type == REQ_EMPTY);
    cmd.row_first  = !row_open;
    cmd.acc_issue  = (state == ST_ACC);
    cmd.emit_issue = (state == ST_EMIT) && !st.rd_pend && !st.out_stall;
    cmd.col        = cnt;
    cmd.col_last   = (cnt == last_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      n_cols   <= NCOL_W'(MAX_COLS);
      cnt      <= '0;
      row_open <= 1'b0;
      blk_last <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) n_cols <= cfg_data;
      if (cmd.blk_load) blk_last <= last_block;
      if (cmd.empty_load) row_open <= 1'b0;
      if (state == ST_DRAIN && !st.pipe_busy) row_open <= !blk_last;
      if (accept || state == ST_DRAIN) cnt <= '0;
      else if (cmd.acc_issue || cmd.emit_issue) cnt <= cnt + COL_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/bsmm_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bsmm_datapath
// B banks, four-lane multiply, accumulator memory and output register.
// ---------------------------------------------------------------------------
module bsmm_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [7:0]                           b_row,
  input  wire logic [5:0]                           b_col,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]    b_value,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]    weight_0,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]    weight_1,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]    weight_2,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]    weight_3,
  input  wire logic [7:0]                           block_start,
  input  wire logic                                 last_row,
  input  wire bsmm_pkg::cmd_t                       cmd,
  output bsmm_pkg::status_t                         st,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [bsmm_pkg::CVAL_W-1:0]        c_value,
  output logic [5:0]                                c_col,
  output logic                                      row_end,
  output logic                                      matrix_end
);
  import bsmm_pkg::*;

  // bank i holds B rows with row mod 4 == i
  logic signed [VAL_W-1:0]  bmem [LANES][BANK_DEPTH];
  logic signed [ACC_W-1:0]  amem [MAX_COLS];

  logic signed [VAL_W-1:0]  w    [LANES];
  logic [ROW_W-3:0]         base;
  logic                     first;
  logic                     last_row_q;
  logic                     zero_q;

  logic signed [VAL_W-1:0]  b_q  [LANES];
  logic signed [ACC_W-1:0]  acc_q;
  logic                     v1, v2;
  logic [COL_W-1:0]         col1, col2;
  logic signed [PROD_W-1:0] p    [LANES];
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  sum;

  logic                     rd_pend;
  logic [COL_W-1:0]         pend_col;
  logic                     pend_last;

  always_ff @(posedge clk) begin
    if (cmd.b_wr && int'(b_row) < DEPTH_K && int'(b_col) < MAX_COLS)
      bmem[b_row[1:0]][{b_row[ROW_W-1:2], b_col[COL_W-1:0]}] <= b_value;
    for (int i = 0; i < LANES; i++)
      b_q[i] <= bmem[i][{base, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      w[0]       <= weight_0;
      w[1]       <= weight_1;
      w[2]       <= weight_2;
      w[3]       <= weight_3;
      base       <= block_start[ROW_W-1:2];
      first      <= cmd.row_first;
      last_row_q <= last_row;
      zero_q     <= 1'b0;
    end else if (cmd.empty_load) begin
      last_row_q <= last_row;
      zero_q     <= 1'b1;
    end
  end

  // accumulator memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.acc_issue || cmd.emit_issue) acc_q <= amem[cmd.col];
    if (v2) amem[col2] <= sum;
  end

  always_ff @(posedge clk) begin
    col1 <= cmd.col;
    col2 <= col1;
    for (int i = 0; i < LANES; i++)
      p[i] <= PROD_W'(w[i]) * PROD_W'(b_q[i]);
    acc_d <= acc_q;
  end

  always_comb begin
    sum = first ? '0 : acc_d;
    for (int i = 0; i < LANES; i++)
      sum = sum + ACC_W'(p[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.acc_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_issue) begin
      pend_col  <= cmd.col;
      pend_last <= cmd.col_last;
    end
    if (rd_pend) begin
      c_value    <= zero_q ? '0 : CVAL_W'(acc_q);
      c_col      <= pend_col;
      row_end    <= pend_last;
      matrix_end <= pend_last && last_row_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.emit_issue;
      if (rd_pend) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign st.pipe_busy = v1 || v2;
  assign st.rd_pend   = rd_pend;
  assign st.out_stall = out_valid && !out_ready;

endmodule
`default_nettype wire

@@ rtl/block_sparse_matrix_multiply.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// block_sparse_matrix_multiply
// Block-sparse (1x4) times dense matrix multiply, Q8.8 in, Q32.16 out.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one transaction per request. Loads
//    write one B element. A block transaction walks the n_cols columns one
//    per cycle, with four multipliers reading four B banks in parallel,
//    then drains a 2-stage pipe. The last block of a row, and an empty-row
//    transaction, then emit n_cols results.
//  - Output channel (out_valid/out_ready): one result transaction per column;
//    the single accumulator read port reads a new column only once the last
//    read sits in the output register. A stalled receiver holds the column walk.
//  - Only one request is in work at a time; in_ready is high while idle,
//    also when the final result of a row still waits in the output register.
//  - Config channel (cfg_valid/cfg_ready): writes n_cols, always ready; write
//    only while idle. Low two bits ignored, zero acts as 4, capped at 64.
//  - Reset (rst, synchronous) closes any open row, sets n_cols to 64 and
//    clears the handshakes. B and accumulator contents are left as they are:
//    B must be loaded before use.
// ---------------------------------------------------------------------------
module block_sparse_matrix_multiply (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            req_type,
  input  wire logic [7:0]                            b_row,
  input  wire logic [5:0]                            b_col,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]     b_value,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]     weight_0,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]     weight_1,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]     weight_2,
  input  wire logic signed [bsmm_pkg::VAL_W-1:0]     weight_3,
  input  wire logic [7:0]                            block_start,
  input  wire logic                                  last_block,
  input  wire logic                                  last_row,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bsmm_pkg::NCOL_W-1:0]           cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [bsmm_pkg::CVAL_W-1:0]         c_value,
  output logic [5:0]                                 c_col,
  output logic                                       row_end,
  output logic                                       matrix_end
);
  import bsmm_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: transaction accept, column counter, row state
  bsmm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .last_block (last_block),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .st         (st),
    .cmd        (cmd)
  );

  // B banks, multiply-accumulate pipe, accumulators, output register
  bsmm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .b_row       (b_row),
    .b_col       (b_col),
    .b_value     (b_value),
    .weight_0    (weight_0),
    .weight_1    (weight_1),
    .weight_2    (weight_2),
    .weight_3    (weight_3),
    .block_start (block_start),
    .last_row    (last_row),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .c_value     (c_value),
    .c_col       (c_col),
    .row_end     (row_end),
    .matrix_end  (matrix_end)
  );

`ifndef ASSERT_OFF
  // accumulate and emit never share the accumulator read port
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.acc_issue && cmd.emit_issue))
    else $error("acc read port conflict");

  // no new emit read while one is still in flight
  a_one_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_issue |-> !st.rd_pend)
    else $error("emit read overlap");

  // a completed read always lands in the output register
  a_pend_lands: assert property (@(posedge clk) disable iff (rst)
    st.rd_pend |=> out_valid)
    else $error("emit read lost");

  // no request accepted while the multiply pipe still writes back
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    st.pipe_busy |-> !in_ready)
    else $error("accept during writeback");
`endif

endmodule
`default_nettype wire

@@ verif/block_sparse_matrix_multiply_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// block_sparse_matrix_multiply_test
// Self-checking bench for the block-sparse multiplier. B rows 0-3 and 252-255
// are preloaded in columns 0-7, then directed and random request streams run
// under several column counts. A local model predicts every column sum and
// the monitor compares each output transaction against the oldest prediction.
// ---------------------------------------------------------------------------
module block_sparse_matrix_multiply_test;
  import bsmm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;   // ignored request code
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE = 120;                // idle cycles before a cfg write
  localparam int PRE_COLS = 8;                // B columns loaded up front

  typedef struct {
    logic [1:0]              kind;
    logic [7:0]              row;
    logic [5:0]              col;
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] w [LANES];
    logic [7:0]              start;
    logic                    blk_end;
    logic                    mat_end;
  } request_t;

  typedef struct {
    logic [CVAL_W-1:0] value;
    logic [5:0]        col;
    logic              r_end;
    logic              m_end;
  } column_sum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [7:0] b_row = '0;
  logic [5:0] b_col = '0;
  logic signed [VAL_W-1:0] b_value = '0;
  logic signed [VAL_W-1:0] weight_0 = '0, weight_1 = '0, weight_2 = '0, weight_3 = '0;
  logic [7:0] block_start = '0;
  logic last_block = 1'b0;
  logic last_row = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [NCOL_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CVAL_W-1:0] c_value;
  logic [5:0] c_col;
  logic row_end;
  logic matrix_end;

  always #5 clk = ~clk;

  block_sparse_matrix_multiply u_dut (
    .clk, .rst, .in_valid, .in_ready, .req_type, .b_row, .b_col, .b_value,
    .weight_0, .weight_1, .weight_2, .weight_3, .block_start, .last_block,
    .last_row, .cfg_valid, .cfg_ready, .cfg_data, .out_valid, .out_ready,
    .c_value, .c_col, .row_end, .matrix_end
  );

  // Shadow copy of the block's state
  logic signed [VAL_W-1:0] b_shadow [DEPTH_K][MAX_COLS];
  logic signed [ACC_W-1:0] acc_shadow [MAX_COLS];
  logic                    row_is_open = 1'b0;
  logic [NCOL_W-1:0]       n_cols_shadow = 7'd64;

  request_t    pending_reqs [$];
  column_sum_t expected_sums [$];
  request_t    cur_req;
  int          errors = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          no_idle = 1'b0;    // set for stretches without idling
  bit          cfg_req = 1'b0;
  logic [NCOL_W-1:0] cfg_req_data;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int active_cols();
    int n;
    n = int'(n_cols_shadow & 7'h7C);
    if (n == 0) n = 4;
    if (n > MAX_COLS) n = MAX_COLS;
    return n;
  endfunction

  // Queue one result per active column; zeros for an empty row
  task automatic push_row_sums(bit zeros, logic mat_end);
    int n;
    column_sum_t s;
    n = active_cols();
    for (int t = 0; t < n; t++) begin
      s.value = zeros ? '0 : {{(CVAL_W-ACC_W){acc_shadow[t][ACC_W-1]}}, acc_shadow[t]};
      s.col   = t[5:0];
      s.r_end = (t == n - 1);
      s.m_end = (t == n - 1) && mat_end;
      expected_sums.push_back(s);
    end
  endtask

  // Advance the shadow state by one accepted request
  task automatic apply_request(request_t q);
    logic [7:0] base;
    logic signed [63:0] sum;
    case (q.kind)
      REQ_LOAD: b_shadow[q.row][q.col] = q.val;
      REQ_BLOCK: begin
        base = q.start & 8'hFC;
        for (int t = 0; t < active_cols(); t++) begin
          sum = 0;
          for (int i = 0; i < LANES; i++)
            sum += 64'(q.w[i]) * 64'(b_shadow[base + i][t]);
          acc_shadow[t] = row_is_open ? ACC_W'(acc_shadow[t] + sum) : ACC_W'(sum);
        end
        if (q.blk_end) begin
          row_is_open = 1'b0;
          push_row_sums(1'b0, q.mat_end);
        end else begin
          row_is_open = 1'b1;
        end
      end
      REQ_EMPTY: begin
        row_is_open = 1'b0;
        push_row_sums(1'b1, q.mat_end);
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", field, got, want, cycles);
  endtask

  // Input driver: slot frees on acceptance, then optional gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request(cur_req);
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          cur_req = pending_reqs.pop_front();
          req_type    <= cur_req.kind;
          b_row       <= cur_req.row;
          b_col       <= cur_req.col;
          b_value     <= cur_req.val;
          weight_0    <= cur_req.w[0];
          weight_1    <= cur_req.w[1];
          weight_2    <= cur_req.w[2];
          weight_3    <= cur_req.w[3];
          block_start <= cur_req.start;
          last_block  <= cur_req.blk_end;
          last_row    <= cur_req.mat_end;
          in_valid    <= 1'b1;
          in_gap = pick_gap();
        end
      end
    end
  end

  // Config writer
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      n_cols_shadow = cfg_data;
      cfg_valid <= 1'b0;
      cfg_req = 1'b0;
    end else if (cfg_req && !cfg_valid) begin
      cfg_data  <= cfg_req_data;
      cfg_valid <= 1'b1;
    end
  end

  // Output monitor and receiver stalls
  always @(posedge clk) begin
    column_sum_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("block_sparse_matrix_multiply verification failed");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          flag_mismatch("unexpected transaction", c_col, 0);
        end else begin
          e = expected_sums.pop_front();
          if (c_value !== e.value)   flag_mismatch("c_value", c_value, e.value);
          if (c_col !== e.col)       flag_mismatch("c_col", c_col, e.col);
          if (row_end !== e.r_end)   flag_mismatch("row_end", row_end, e.r_end);
          if (matrix_end !== e.m_end) flag_mismatch("matrix_end", matrix_end, e.m_end);
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < 12) out_gap = pick_gap();
      end
    end
  end

  // ---- stimulus helpers ----
  function automatic request_t rand_req(logic [1:0] kind);
    request_t q;
    int bases [2] = '{0, 252};   // only preloaded B groups are read
    q.kind  = kind;
    q.row   = 8'($urandom);
    q.col   = 6'($urandom);
    q.val   = 16'($urandom);
    for (int i = 0; i < LANES; i++) begin
      case ($urandom_range(9))
        0:       q.w[i] = 16'sh8000;
        1:       q.w[i] = 16'sh7FFF;
        default: q.w[i] = 16'($urandom);
      endcase
    end
    q.start   = 8'(bases[$urandom_range(1)] | $urandom_range(3));
    q.blk_end = 1'($urandom);
    q.mat_end = 1'($urandom);
    return q;
  endfunction

  task automatic queue_block(bit ends_row);
    request_t q;
    q = rand_req(REQ_BLOCK);
    q.blk_end = ends_row;
    pending_reqs.push_back(q);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_sums.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_n_cols(logic [NCOL_W-1:0] v);
    cfg_req_data = v;
    cfg_req = 1'b1;
    while (cfg_req) @(negedge clk);
  endtask

  // Random mix; every pattern leaves the row closed
  task automatic queue_random(int count);
    int made, r, k;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 60) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(5) == 0) begin
            pending_reqs.push_back(rand_req(REQ_LOAD));   // load inside a row
            made++;
          end
          queue_block(i == k - 1);
        end
        made += k;
      end else if (r < 75) begin
        pending_reqs.push_back(rand_req(REQ_LOAD));
        made++;
      end else if (r < 85) begin
        pending_reqs.push_back(rand_req(REQ_EMPTY));
        made++;
      end else if (r < 90) begin
        pending_reqs.push_back(rand_req(REQ_UNUSED));
      end else begin
        // row abandoned by an empty-row request
        k = $urandom_range(1, 2);
        for (int i = 0; i < k; i++) queue_block(1'b0);
        pending_reqs.push_back(rand_req(REQ_EMPTY));
        made += k + 1;
      end
    end
  endtask

  initial begin
    request_t q;
    int phase_cols [5] = '{4, 0, 11, 7, 8};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty rows at the reset column count and above the column limit
    q = rand_req(REQ_EMPTY); q.mat_end = 1'b1;
    pending_reqs.push_back(q);
    wait_idle();
    write_n_cols(7'd127);
    pending_reqs.push_back(rand_req(REQ_EMPTY));
    wait_idle();
    write_n_cols(NCOL_W'(PRE_COLS));

    // Preload B groups 0 and 63 in the first columns, full-range values
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < PRE_COLS; c++) begin
        q = rand_req(REQ_LOAD);
        q.row = (r < 4) ? 8'(r) : 8'(248 + r);
        q.col = 6'(c);
        if (r == 0) q.val = 16'sh8000;
        if (r == 1) q.val = 16'sh7FFF;
        pending_reqs.push_back(q);
      end
    end

    // Directed part at eight columns
    q = rand_req(REQ_BLOCK);                     // all weights negative full scale
    q.start = 8'd0; q.blk_end = 1'b1; q.mat_end = 1'b0;
    for (int i = 0; i < LANES; i++) q.w[i] = 16'sh8000;
    pending_reqs.push_back(q);
    q.w = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    q.start = 8'd255; q.mat_end = 1'b1;          // top group, low bits set
    pending_reqs.push_back(q);
    q = rand_req(REQ_BLOCK);                     // non-final block with last_row
    q.blk_end = 1'b0; q.mat_end = 1'b1;
    pending_reqs.push_back(q);
    pending_reqs.push_back(rand_req(REQ_LOAD));  // load while the row is open
    q = rand_req(REQ_BLOCK);
    q.blk_end = 1'b1; q.mat_end = 1'b0;
    pending_reqs.push_back(q);
    q = rand_req(REQ_EMPTY); q.mat_end = 1'b0;
    pending_reqs.push_back(q);
    q.mat_end = 1'b1;
    pending_reqs.push_back(q);
    q = rand_req(REQ_BLOCK); q.blk_end = 1'b0;   // open row dropped by empty row
    pending_reqs.push_back(q);
    q = rand_req(REQ_EMPTY);
    pending_reqs.push_back(q);
    pending_reqs.push_back(rand_req(REQ_UNUSED));
    q = rand_req(REQ_BLOCK);                     // zero weights
    q.w = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}; q.blk_end = 1'b1;
    pending_reqs.push_back(q);
    wait_idle();

    // Random phases, each under a new column count
    for (int p = 0; p < 5; p++) begin
      write_n_cols(NCOL_W'(phase_cols[p]));
      no_idle = (p == 2);
      queue_random(5);
      if (p == 1) wait_idle();                   // sender holds until drained
      queue_random(5);
      wait_idle();
    end
    write_n_cols(NCOL_W'(PRE_COLS));
    no_idle = 1'b0;
    queue_random(4);
    wait_idle();

    if (errors == 0) begin
      $display("block_sparse_matrix_multiply verification clean");
    end else begin
      $display("block_sparse_matrix_multiply verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bsmm_pkg.sv
rtl/bsmm_ctrl.sv
rtl/bsmm_datapath.sv
rtl/block_sparse_matrix_multiply.sv
verif/block_sparse_matrix_multiply_test.sv
